// ===== rtl/ndc_pkg.sv =====
// Shared types and constants for the nested delimiter counter.
// Used by ndc_cell, ndc_rsp_queue and nested_delimiter_counter_core.
package ndc_pkg;

   // default sizes
   localparam int MAX_LEVELS_DEF  = 16;
   localparam int COUNT_BITS_DEF  = 16;
   localparam int RSP_COUNT_BITS  = 16;
   localparam int CHAR_BITS       = 8;
   localparam int QUEUE_DEPTH     = 4;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTRUCT      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONSTITUENT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUBCONSTITUENT = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEST_OPEN      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEST_CLOSE     = 3'd4;

   // mark values after reset
   localparam logic [CHAR_BITS-1:0] CONSTRUCT_RST      = 8'd43;
   localparam logic [CHAR_BITS-1:0] CONSTITUENT_RST    = 8'd32;
   localparam logic [CHAR_BITS-1:0] SUBCONSTITUENT_RST = 8'd42;
   localparam logic [CHAR_BITS-1:0] NEST_OPEN_RST      = 8'd123;
   localparam logic [CHAR_BITS-1:0] NEST_CLOSE_RST     = 8'd125;

   typedef enum logic [2:0] {
      STATUS_OK              = 3'd0,
      STATUS_UNBALANCED      = 3'd1,
      STATUS_BAD_CONSTRUCT   = 3'd2,
      STATUS_BAD_CONSTITUENT = 3'd3,
      STATUS_OVERFLOW        = 3'd4
   } status_type;

   typedef enum logic {
      KIND_COUNT  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   // command from the control logic to one stack cell
   typedef struct packed {
      logic clear;     // end of text: drop everything
      logic push;      // take the value of the cell above
      logic pop;       // take the value of the cell below
      logic zero;      // top only: construct closed
      logic inc_con;   // top only
      logic inc_sub;   // top only
   } cell_cmd_type;

   // one response record
   typedef struct packed {
      kind_type                  kind;
      logic [RSP_COUNT_BITS-1:0] con;
      logic [RSP_COUNT_BITS-1:0] sub;
      status_type                status;
      logic                      last;
   } rsp_rec_type;

endpackage

// ===== rtl/ndc_cell.sv =====
// One level of the counter stack: a constituent and a subconstituent counter.
// Depends on ndc_pkg; chained in nested_delimiter_counter_core.
module ndc_cell import ndc_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [COUNT_BITS-1:0] above_con,
   input  logic [COUNT_BITS-1:0] above_sub,
   input  logic [COUNT_BITS-1:0] below_con,
   input  logic [COUNT_BITS-1:0] below_sub,
   output logic [COUNT_BITS-1:0] con,
   output logic [COUNT_BITS-1:0] sub
);

   logic [COUNT_BITS-1:0] con_ff, con_in;
   logic [COUNT_BITS-1:0] sub_ff, sub_in;

   // clear, shift along the chain, or count in place at the top
   always_comb begin
      con_in = con_ff;
      sub_in = sub_ff;
      if (cmd.clear || cmd.zero) begin
         con_in = '0;
         sub_in = '0;
      end else if (cmd.push) begin
         con_in = above_con;
         sub_in = above_sub;
      end else if (cmd.pop) begin
         con_in = below_con;
         sub_in = below_sub;
      end else begin
         // saturating counts
         if (cmd.inc_con && (con_ff != '1)) con_in = con_ff + 1'b1;
         if (cmd.inc_sub && (sub_ff != '1)) sub_in = sub_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         con_ff <= '0;
         sub_ff <= '0;
      end else begin
         con_ff <= con_in;
         sub_ff <= sub_in;
      end
   end

   assign con = con_ff;
   assign sub = sub_ff;

endmodule

// ===== rtl/ndc_rsp_queue.sv =====
// Shifting response queue: takes up to two records a cycle, gives one on each read.
// Depends on ndc_pkg; used by nested_delimiter_counter_core.
module ndc_rsp_queue import ndc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       wr_count,   // records written this cycle
   input  rsp_rec_type      wr_a,
   input  rsp_rec_type      wr_b,
   input  logic             rd,
   output rsp_rec_type      head,
   output logic [CNT_W-1:0] fill
);

   rsp_rec_type      entry_ff [DEPTH];
   rsp_rec_type      entry_in [DEPTH];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] base;

   assign base = fill_ff - CNT_W'(rd);

   // each entry moves one place towards the head on a read and
   // picks up a new record when it is the next free place
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         if (rd && (i < DEPTH - 1)) entry_in[i] = entry_ff[(i + 1) % DEPTH];
         else                       entry_in[i] = entry_ff[i];
         if ((wr_count != 2'd0) && (CNT_W'(i) == base))
            entry_in[i] = wr_a;
         else if ((wr_count == 2'd2) && (CNT_W'(i) == base + 1'b1))
            entry_in[i] = wr_b;
      end
      fill_in = base + CNT_W'(wr_count);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) entry_ff[i] <= entry_in[i];
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else       fill_ff <= fill_in;
   end

   assign head = entry_ff[0];
   assign fill = fill_ff;

endmodule

// ===== rtl/nested_delimiter_counter_core.sv =====
// Nested delimiter counter: counts constituent and subconstituent marks
// per nesting level of annotated text and checks the delimiter structure.
// Request channel: one text byte (req_character) and an end-of-text flag
// (req_final_req) per request, taken when req_valid is high and req_stall
// low. Response channel: count records (rsp_kind 0) for every well-formed
// closed construct while no error is latched, and one status record
// (rsp_kind 1, rsp_last_of_run 1) after the last byte of each text. A nonzero
// status means the count records of that text must be thrown away.
// Throughput: one request per cycle while req_stall is low. A request may
// cause two responses; they drain one per cycle, while rsp_stall is low,
// through a four-entry queue, and req_stall rises when fewer than two places
// are free, so the response side sets the pace. The stack is a chain of
// counter cells, the top cell holding the current level; open and close
// marks shift the whole chain by one place. Reset (synchronous) restores the
// default marks and empties stack and queue; no clearing pass is needed.
// A stalled response holds until taken. The user must write the marks through
// csr_write/csr_index/csr_data only while idle; the core does not enforce it.
module nested_delimiter_counter_core import ndc_pkg::*; #(
   parameter int MAX_LEVELS = MAX_LEVELS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CHAR_BITS-1:0]      req_character,
   input  logic                      req_final_req,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic [RSP_COUNT_BITS-1:0] rsp_constituent_count,
   output logic [RSP_COUNT_BITS-1:0] rsp_subconstituent_count,
   output logic [2:0]                rsp_status,
   output logic                      rsp_last_of_run,
   // configuration
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CHAR_BITS-1:0]      csr_data
);

   localparam int LEVEL_BITS = $clog2(MAX_LEVELS);
   localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
   localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(MAX_LEVELS - 1);

   logic [CHAR_BITS-1:0] construct_ff, constituent_ff, subconstituent_ff;
   logic [CHAR_BITS-1:0] open_ff, close_ff;

   logic [LEVEL_BITS-1:0] level_ff, level_in;
   logic [CHAR_BITS-1:0]  prev_ff, prev_in, prev2_ff, prev2_in;
   status_type            error_ff, error_in, error_mid;

   logic req_fire, rsp_fire;
   logic is_open, is_close, is_cons, is_con, is_sub;
   logic do_push, do_pop, bad_cons, emit_cnt;

   cell_cmd_type          top_cmd, rest_cmd;
   logic [COUNT_BITS-1:0] con_q [MAX_LEVELS + 1];
   logic [COUNT_BITS-1:0] sub_q [MAX_LEVELS + 1];

   rsp_rec_type       rec_cnt, rec_stat, wr_a, wr_b, head;
   logic [1:0]        wr_count;
   logic [FILL_W-1:0] fill;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   // mark registers
   always_ff @(posedge clock) begin
      if (reset) begin
         construct_ff      <= CONSTRUCT_RST;
         constituent_ff    <= CONSTITUENT_RST;
         subconstituent_ff <= SUBCONSTITUENT_RST;
         open_ff           <= NEST_OPEN_RST;
         close_ff          <= NEST_CLOSE_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CONSTRUCT:      construct_ff      <= csr_data;
            CSR_CONSTITUENT:    constituent_ff    <= csr_data;
            CSR_SUBCONSTITUENT: subconstituent_ff <= csr_data;
            CSR_NEST_OPEN:      open_ff           <= csr_data;
            CSR_NEST_CLOSE:     close_ff          <= csr_data;
            default: ;
         endcase
      end
   end

   // decode: first matching mark wins
   assign is_open  = (req_character == open_ff);
   assign is_close = !is_open && (req_character == close_ff);
   assign is_cons  = !is_open && !is_close && (req_character == construct_ff);
   assign is_con   = !is_open && !is_close && !is_cons &&
                     (req_character == constituent_ff);
   assign is_sub   = !is_open && !is_close && !is_cons && !is_con &&
                     (req_character == subconstituent_ff);

   assign bad_cons = (prev_ff != constituent_ff) || (prev2_ff != subconstituent_ff);
   assign do_push  = req_fire && is_open && (level_ff != TOP_LEVEL);
   assign do_pop   = req_fire && is_close && (level_ff != '0);
   assign emit_cnt = req_fire && is_cons && !bad_cons && (error_ff == STATUS_OK);

   // structure check, level and character history
   always_comb begin
      error_mid = error_ff;
      if (error_ff == STATUS_OK) begin
         if (is_open && (level_ff == TOP_LEVEL))  error_mid = STATUS_OVERFLOW;
         else if (is_close && (level_ff == '0))   error_mid = STATUS_UNBALANCED;
         else if (is_cons && bad_cons)            error_mid = STATUS_BAD_CONSTRUCT;
         else if (is_con && (prev_ff != subconstituent_ff))
            error_mid = STATUS_BAD_CONSTITUENT;
      end

      level_in = level_ff;
      if (do_push)     level_in = level_ff + 1'b1;
      else if (do_pop) level_in = level_ff - 1'b1;

      // open levels left at the end of the text
      if ((error_mid == STATUS_OK) && (level_in != '0) && req_final_req)
         error_mid = STATUS_UNBALANCED;

      error_in = error_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      if (req_fire) begin
         error_in = error_mid;
         prev_in  = req_character;
         prev2_in = prev_ff;
         if (req_final_req) begin
            level_in = '0;
            error_in = STATUS_OK;
            prev_in  = '0;
            prev2_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         error_ff <= STATUS_OK;
         prev_ff  <= '0;
         prev2_ff <= '0;
      end else begin
         level_ff <= level_in;
         error_ff <= error_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
      end
   end

   // commands for the cell chain
   always_comb begin
      rest_cmd         = '0;
      rest_cmd.clear   = req_fire && req_final_req;
      rest_cmd.push    = do_push;
      rest_cmd.pop     = do_pop;
      top_cmd          = rest_cmd;
      top_cmd.zero     = req_fire && is_cons;
      top_cmd.inc_con  = req_fire && is_con;
      top_cmd.inc_sub  = req_fire && is_sub;
   end

   // chain of stack cells; cell 0 is the current level
   assign con_q[MAX_LEVELS] = '0;
   assign sub_q[MAX_LEVELS] = '0;

   for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
      if (i == 0) begin : g_top
         ndc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (top_cmd),
            .above_con ('0),
            .above_sub ('0),
            .below_con (con_q[1]),
            .below_sub (sub_q[1]),
            .con       (con_q[0]),
            .sub       (sub_q[0])
         );
      end else begin : g_rest
         ndc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (rest_cmd),
            .above_con (con_q[i-1]),
            .above_sub (sub_q[i-1]),
            .below_con (con_q[i+1]),
            .below_sub (sub_q[i+1]),
            .con       (con_q[i]),
            .sub       (sub_q[i])
         );
      end
   end

   // response records
   always_comb begin
      rec_cnt.kind   = KIND_COUNT;
      rec_cnt.con    = RSP_COUNT_BITS'({{RSP_COUNT_BITS{1'b0}}, con_q[0]});
      rec_cnt.sub    = RSP_COUNT_BITS'({{RSP_COUNT_BITS{1'b0}}, sub_q[0]});
      rec_cnt.status = STATUS_OK;
      rec_cnt.last   = 1'b0;

      rec_stat.kind   = KIND_STATUS;
      rec_stat.con    = '0;
      rec_stat.sub    = '0;
      rec_stat.status = error_mid;
      rec_stat.last   = 1'b1;

      wr_a     = emit_cnt ? rec_cnt : rec_stat;
      wr_b     = rec_stat;
      wr_count = 2'(emit_cnt) + 2'(req_fire && req_final_req);
   end

   ndc_rsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_count (wr_count),
      .wr_a     (wr_a),
      .wr_b     (wr_b),
      .rd       (rsp_fire),
      .head     (head),
      .fill     (fill)
   );

   // room for two records is needed before a request is taken
   assign req_stall = (fill > FILL_W'(QUEUE_DEPTH - 2));

   assign rsp_valid                = (fill != '0);
   assign rsp_kind                 = head.kind;
   assign rsp_constituent_count    = head.con;
   assign rsp_subconstituent_count = head.sub;
   assign rsp_status               = head.status;
   assign rsp_last_of_run          = head.last;

   // end of text leaves a clean run state
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_final_req |=> (level_ff == '0) && (error_ff == STATUS_OK))
      else $error("run state not cleared after last character");

   // a request that produces a record shows a response next cycle
   a_record_shows: assert property (@(posedge clock) disable iff (reset)
      req_fire && (emit_cnt || req_final_req) |=> rsp_valid)
      else $error("record lost");

   // a latched error holds until the end of the text
   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      (error_ff != STATUS_OK) && !(req_fire && req_final_req) |=>
      error_ff == $past(error_ff))
      else $error("latched error changed");

   // no count record while an error is latched
   a_no_count_after_error: assert property (@(posedge clock) disable iff (reset)
      (error_ff != STATUS_OK) |-> !emit_cnt)
      else $error("count record after error");

endmodule

// ===== bench/ndc_count_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for nested_delimiter_counter_core: watches the request, response and mark ports,
// predicts the records of every accepted request and compares them in order.
// Depends on ndc_pkg for the record layout, status codes, mark indexes and sizes.
module ndc_count_checker import ndc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [CHAR_BITS-1:0]      req_character,
   input  logic                      req_final_req,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      rsp_kind,
   input  logic [RSP_COUNT_BITS-1:0] rsp_constituent_count,
   input  logic [RSP_COUNT_BITS-1:0] rsp_subconstituent_count,
   input  logic [2:0]                rsp_status,
   input  logic                      rsp_last_of_run,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CHAR_BITS-1:0]      csr_data,
   output int                        mismatches,
   output int                        records_due
);

   localparam logic [COUNT_BITS_DEF-1:0] COUNT_TOP = '1;

   // mark registers as the block should hold them
   logic [CHAR_BITS-1:0] construct_mark, constituent_mark, sub_mark, open_mark, close_mark;

   // per-text state
   int                        depth;
   logic [COUNT_BITS_DEF-1:0] con_stack [MAX_LEVELS_DEF];
   logic [COUNT_BITS_DEF-1:0] sub_stack [MAX_LEVELS_DEF];
   logic [CHAR_BITS-1:0]      last_char, char_before;
   status_type                text_status;

   // records still owed by the block, oldest first
   rsp_rec_type due_records [$];

   function automatic void clear_text();
      depth = 0;
      foreach (con_stack[i]) begin
         con_stack[i] = '0;
         sub_stack[i] = '0;
      end
      last_char   = '0;
      char_before = '0;
      text_status = STATUS_OK;
   endfunction

   // only the first error of a text sticks
   function automatic void note_error(input status_type code);
      if (text_status == STATUS_OK)
         text_status = code;
   endfunction

   // append to the owed records
   function automatic void owe_record(input rsp_rec_type rec);
      due_records = {due_records, rec};
   endfunction

   // one text byte: update the stack and queue whatever records it causes
   function automatic void scan_char(input logic [CHAR_BITS-1:0] ch, input logic fin);
      rsp_rec_type rec;
      if (ch == open_mark) begin
         if (depth + 1 >= MAX_LEVELS_DEF)
            note_error(STATUS_OVERFLOW);
         else begin
            depth++;
            con_stack[depth] = '0;
            sub_stack[depth] = '0;
         end
      end else if (ch == close_mark) begin
         if (depth == 0)
            note_error(STATUS_UNBALANCED);
         else begin
            con_stack[depth] = '0;
            sub_stack[depth] = '0;
            depth--;
         end
      end else if (ch == construct_mark) begin
         if (last_char != constituent_mark || char_before != sub_mark)
            note_error(STATUS_BAD_CONSTRUCT);
         if (text_status == STATUS_OK) begin
            rec = '{kind: KIND_COUNT,
                    con: RSP_COUNT_BITS'(con_stack[depth]),
                    sub: RSP_COUNT_BITS'(sub_stack[depth]),
                    status: STATUS_OK, last: 1'b0};
            owe_record(rec);
         end
         con_stack[depth] = '0;
         sub_stack[depth] = '0;
      end else if (ch == constituent_mark) begin
         if (last_char != sub_mark)
            note_error(STATUS_BAD_CONSTITUENT);
         if (con_stack[depth] != COUNT_TOP)
            con_stack[depth]++;
      end else if (ch == sub_mark) begin
         if (sub_stack[depth] != COUNT_TOP)
            sub_stack[depth]++;
      end

      char_before = last_char;
      last_char   = ch;

      // end of text: status record, then a fresh start
      if (fin) begin
         if (depth != 0)
            note_error(STATUS_UNBALANCED);
         rec = '{kind: KIND_STATUS, con: '0, sub: '0, status: text_status, last: 1'b1};
         owe_record(rec);
         clear_text();
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: rsp %s expected %0d got %0d", $time, name, want, got);
      end
   endfunction

   function automatic void take_record();
      rsp_rec_type want;
      if (due_records.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected record expected none got kind %0d con %0d sub %0d %s %0d",
                  $time, rsp_kind, rsp_constituent_count, rsp_subconstituent_count,
                  "status", rsp_status);
         return;
      end
      want = due_records.pop_front();
      check_field("kind", want.kind, rsp_kind);
      check_field("constituent_count", want.con, rsp_constituent_count);
      check_field("subconstituent_count", want.sub, rsp_subconstituent_count);
      check_field("status", want.status, rsp_status);
      check_field("last_of_run", want.last, rsp_last_of_run);
   endfunction

   // responses first: they always belong to earlier requests
   always @(posedge clock) begin
      if (reset) begin
         construct_mark   = CONSTRUCT_RST;
         constituent_mark = CONSTITUENT_RST;
         sub_mark         = SUBCONSTITUENT_RST;
         open_mark        = NEST_OPEN_RST;
         close_mark       = NEST_CLOSE_RST;
         clear_text();
         due_records.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            take_record();
         if (req_valid && !req_stall)
            scan_char(req_character, req_final_req);
         if (csr_write) begin
            case (csr_index)
               CSR_CONSTRUCT:      construct_mark   = csr_data;
               CSR_CONSTITUENT:    constituent_mark = csr_data;
               CSR_SUBCONSTITUENT: sub_mark         = csr_data;
               CSR_NEST_OPEN:      open_mark        = csr_data;
               CSR_NEST_CLOSE:     close_mark       = csr_data;
               default: ;  // unused index, ignored
            endcase
         end
      end
      records_due <= due_records.size();
   end

endmodule

// ===== bench/nested_delimiter_counter_core_test.sv =====
`timescale 1ns / 1ps
// Top of the nested_delimiter_counter_core bench: clock, reset, text stimulus, mark writes
// and response back-pressure; checking is left to ndc_count_checker. Depends on ndc_pkg.
module nested_delimiter_counter_core_test;
   import ndc_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;

   logic clock;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [CHAR_BITS-1:0]      req_character = '0;
   logic                      req_final_req = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic                      rsp_kind;
   logic [RSP_COUNT_BITS-1:0] rsp_constituent_count;
   logic [RSP_COUNT_BITS-1:0] rsp_subconstituent_count;
   logic [2:0]                rsp_status;
   logic                      rsp_last_of_run;
   logic                      csr_write     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = '0;
   logic [CHAR_BITS-1:0]      csr_data      = '0;

   int mismatches;
   int records_due;

   // marks as last written, used to build texts
   logic [CHAR_BITS-1:0] mk_construct = CONSTRUCT_RST;
   logic [CHAR_BITS-1:0] mk_con       = CONSTITUENT_RST;
   logic [CHAR_BITS-1:0] mk_sub       = SUBCONSTITUENT_RST;
   logic [CHAR_BITS-1:0] mk_open      = NEST_OPEN_RST;
   logic [CHAR_BITS-1:0] mk_close     = NEST_CLOSE_RST;
   logic [CHAR_BITS-1:0] mark_draw [5];

   logic [CHAR_BITS-1:0] text_bytes [$];
   int                   items_sent = 0;
   bit                   idle_on    = 1'b1;
   int                   hold_asks  = 0;
   int                   hold_done  = 0;
   int                   quiet_cycles = 0;

   nested_delimiter_counter_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_character(req_character), .req_final_req(req_final_req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_constituent_count(rsp_constituent_count),
      .rsp_subconstituent_count(rsp_subconstituent_count),
      .rsp_status(rsp_status), .rsp_last_of_run(rsp_last_of_run),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   ndc_count_checker count_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_character(req_character), .req_final_req(req_final_req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_constituent_count(rsp_constituent_count),
      .rsp_subconstituent_count(rsp_subconstituent_count),
      .rsp_status(rsp_status), .rsp_last_of_run(rsp_last_of_run),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .mismatches(mismatches), .records_due(records_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      if (!idle_on)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // append one byte to the text being built
   function automatic void add_byte(input logic [CHAR_BITS-1:0] b);
      text_bytes = {text_bytes, b};
   endfunction

   function automatic bit is_mark(input logic [CHAR_BITS-1:0] b);
      return b == mk_construct || b == mk_con || b == mk_sub || b == mk_open || b == mk_close;
   endfunction

   function automatic logic [CHAR_BITS-1:0] filler();
      logic [CHAR_BITS-1:0] b;
      do b = CHAR_BITS'($urandom_range(0, 255)); while (is_mark(b));
      return b;
   endfunction

   function automatic logic [CHAR_BITS-1:0] pick_mark();
      case ($urandom_range(0, 4))
         0: return mk_construct;
         1: return mk_con;
         2: return mk_sub;
         3: return mk_open;
         default: return mk_close;
      endcase
   endfunction

   // well-formed text: constructs of constituents, each ending sub then constituent mark,
   // with nesting opened and closed between constituents, any level still open closed at the end
   function automatic void build_good(input int constructs);
      int nest;
      nest = 0;
      repeat (constructs) begin
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(0, 2)) add_byte(filler());
            if ($urandom_range(0, 3) == 0 && nest < 5) begin
               add_byte(mk_open);
               nest++;
            end else if ($urandom_range(0, 3) == 0 && nest > 0) begin
               add_byte(mk_close);
               nest--;
            end
            repeat ($urandom_range(1, 3)) begin
               if ($urandom_range(0, 2) == 0)
                  add_byte(filler());
               add_byte(mk_sub);
            end
            add_byte(mk_con);
         end
         add_byte(mk_construct);
      end
      repeat (nest) add_byte(mk_close);
   endfunction

   // one byte replaced, dropped or added
   function automatic void break_text();
      int at;
      at = $urandom_range(0, text_bytes.size() - 1);
      case ($urandom_range(0, 2))
         0: text_bytes[at] = pick_mark();
         1: text_bytes.delete(at);
         default: text_bytes.insert(at, pick_mark());
      endcase
   endfunction

   function automatic void build_noise();
      repeat ($urandom_range(1, 16)) begin
         if ($urandom_range(0, 9) < 6)
            add_byte(pick_mark());
         else
            add_byte(CHAR_BITS'($urandom_range(0, 255)));
      end
   endfunction

   // nesting around the stack limit, some levels with a construct inside
   function automatic void build_deep();
      int n;
      n = $urandom_range(12, 18);
      repeat (n) begin
         add_byte(mk_open);
         if ($urandom_range(0, 2) == 0) begin
            add_byte(mk_sub);
            add_byte(mk_con);
            add_byte(mk_construct);
         end
      end
      repeat (n) add_byte(mk_close);
   endfunction

   function automatic void draw_distinct();
      bit clash;
      do begin
         clash = 1'b0;
         foreach (mark_draw[i]) mark_draw[i] = CHAR_BITS'($urandom_range(0, 255));
         foreach (mark_draw[i])
            for (int j = 0; j < i; j++)
               if (mark_draw[i] == mark_draw[j]) clash = 1'b1;
      end while (clash);
   endfunction

   // one request; valid stays up straight into the next one when there is no gap
   task automatic send_item(input logic [CHAR_BITS-1:0] ch, input logic fin);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= ch;
      req_final_req <= fin;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_text();
      foreach (text_bytes[i]) send_item(text_bytes[i], i == text_bytes.size() - 1);
      text_bytes.delete();
   endtask

   // stop sending and let every owed record drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (records_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all five marks, preceded by a write to an unused index
   task automatic set_marks(input logic [CHAR_BITS-1:0] c, input logic [CHAR_BITS-1:0] con,
                            input logic [CHAR_BITS-1:0] sub, input logic [CHAR_BITS-1:0] op,
                            input logic [CHAR_BITS-1:0] cl);
      csr_write <= 1'b1;
      csr_index <= CSR_INDEX_BITS'($urandom_range(CSR_NEST_CLOSE + 1, (1 << CSR_INDEX_BITS) - 1));
      csr_data  <= CHAR_BITS'($urandom_range(0, 255));
      @(posedge clock);
      csr_index <= CSR_CONSTRUCT;      csr_data <= c;   @(posedge clock);
      csr_index <= CSR_CONSTITUENT;    csr_data <= con; @(posedge clock);
      csr_index <= CSR_SUBCONSTITUENT; csr_data <= sub; @(posedge clock);
      csr_index <= CSR_NEST_OPEN;      csr_data <= op;  @(posedge clock);
      csr_index <= CSR_NEST_CLOSE;     csr_data <= cl;  @(posedge clock);
      csr_write <= 1'b0;
      mk_construct = c;
      mk_con       = con;
      mk_sub       = sub;
      mk_open      = op;
      mk_close     = cl;
   endtask

   // mostly well-formed texts with random content, the rest broken, noise or deep nesting
   task automatic random_phase(input int target);
      int start, pick, texts;
      start = items_sent;
      texts = 0;
      while (items_sent - start < target) begin
         idle_on = ($urandom_range(0, 4) != 0);
         pick = $urandom_range(0, 99);
         if (texts % 12 == 5 || pick < 6)
            build_deep();
         else if (pick < 18)
            build_noise();
         else begin
            build_good($urandom_range(1, 5));
            if (pick < 33)
               break_text();
         end
         send_text();
         texts++;
      end
   endtask

   // response side: random stalls, plus a long hold-off when asked for
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != hold_done) begin
            hold_done++;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0)
            stall_left = gap_len();
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else
            rsp_stall <= 1'b0;
      end
   end

   // watchdog: too long without a request moving or an owed response arriving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) ||
          (rsp_valid && !rsp_stall && (records_due != 0)))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [CHAR_BITS-1:0] pool [3];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed texts with the reset marks
      text_bytes = '{SUBCONSTITUENT_RST, SUBCONSTITUENT_RST, CONSTITUENT_RST, CONSTRUCT_RST};
      send_text();
      // record inside a nested level, then a close too many
      text_bytes = '{NEST_OPEN_RST, SUBCONSTITUENT_RST, CONSTITUENT_RST, CONSTRUCT_RST,
                     NEST_CLOSE_RST, NEST_CLOSE_RST};
      send_text();
      // constituent mark with no subconstituent before it
      text_bytes = '{CONSTITUENT_RST, CONSTRUCT_RST};
      send_text();
      // construct mark out of place
      text_bytes = '{filler(), CONSTRUCT_RST};
      send_text();
      // level left open at the end
      text_bytes = '{NEST_OPEN_RST};
      send_text();
      text_bytes = '{8'h00};
      send_text();
      text_bytes = '{8'hFF};
      send_text();

      // long hold-off on the response side while requests keep coming
      idle_on = 1'b0;
      hold_asks <= hold_asks + 1;
      build_good(12);
      send_text();
      random_phase(200);

      // random distinct marks
      settle();
      draw_distinct();
      set_marks(mark_draw[0], mark_draw[1], mark_draw[2], mark_draw[3], mark_draw[4]);
      random_phase(200);

      // marks at the ends of the byte range
      settle();
      set_marks(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80);
      random_phase(75);
      settle();
      set_marks(8'hFF, 8'h00, 8'hFE, 8'h01, 8'h7F);
      random_phase(75);

      // marks sharing values, so the priority between them decides
      settle();
      foreach (pool[i]) pool[i] = CHAR_BITS'($urandom_range(0, 255));
      set_marks(pool[$urandom_range(0, 2)], pool[$urandom_range(0, 2)],
                pool[$urandom_range(0, 2)], pool[$urandom_range(0, 2)],
                pool[$urandom_range(0, 2)]);
      random_phase(150);

      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
